### sv/filtered_histogram_mode_top_macros.svh
// Assertion macros for the filtered histogram mode block.
// Needs nothing else; the SYNTH macro selects the empty forms.
`ifndef FILTERED_HISTOGRAM_MODE_TOP_MACROS_SVH
`define FILTERED_HISTOGRAM_MODE_TOP_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge out of reset
`define FHM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("fhm assertion failed");
// condition must never be seen out of reset
`define FHM_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("fhm forbidden condition seen");
`else
`define FHM_ASSERT(lbl, clk, rstn, prop)
`define FHM_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

### sv/fhm_pkg.sv
// Shared types and constants of the filtered histogram mode block.
// No dependencies.
package fhm_pkg;

  localparam int unsigned NUM_VALUES_DEF = 16;
  localparam int unsigned NUM_FEATURES   = 16;
  localparam int unsigned FIELD_W        = 4;
  localparam int unsigned COUNT_W        = 13;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 4;

  // counting filter
  typedef enum logic [1:0] {
    STRAT_FIXED     = 2'd0,
    STRAT_ALL       = 2'd1,
    STRAT_FOLLOW    = 2'd2,
    STRAT_NONFOLLOW = 2'd3
  } strategy_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STRATEGY     = 2'd0,
    CFG_EDIT_SECTION = 2'd1,
    CFG_FOLLOWER     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [FIELD_W-1:0] feature_index;
    logic [FIELD_W-1:0] agent_value;
    logic [FIELD_W-1:0] agent_section_value;
    logic [FIELD_W-1:0] media_value;
    logic               is_last;
  } item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] new_value;
    logic               changed;
  } result_t;

  // what the scan needs from the last request of a run
  typedef struct packed {
    logic [FIELD_W-1:0] media;
    logic               skip;
  } run_t;

endpackage

### sv/fhm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module fhm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/fhm_update.sv
// Histogram increment pipeline: filter, bin read, saturating add, write back.
// Depends on fhm_pkg; drives the bin RAM ports in the top level.
module fhm_update #(
  parameter int unsigned NUM_VALUES = fhm_pkg::NUM_VALUES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  fhm_pkg::item_t                 item_i,
  input  fhm_pkg::strategy_e             strategy_i,
  input  logic [fhm_pkg::FIELD_W-1:0]    follower_i,
  input  logic                           flush_i,
  output logic [$clog2(NUM_VALUES)-1:0]  raddr_o,
  input  logic [fhm_pkg::COUNT_W-1:0]    rdata_i,
  output logic                           we_o,
  output logic [$clog2(NUM_VALUES)-1:0]  waddr_o,
  output logic [fhm_pkg::COUNT_W-1:0]    wdata_o
);

  localparam int unsigned AW = $clog2(NUM_VALUES);

  logic                        follower;
  logic                        counted;
  logic                        in_range;
  logic                        s1_vld_q;
  logic [AW-1:0]               s1_addr_q;
  logic                        fwd_vld_q;
  logic [AW-1:0]               fwd_addr_q;
  logic [fhm_pkg::COUNT_W-1:0] fwd_data_q;
  logic [fhm_pkg::COUNT_W-1:0] base;

  // agent filter
  assign follower = (item_i.agent_section_value == follower_i);

  always_comb begin
    case (strategy_i)
      fhm_pkg::STRAT_ALL:       counted = 1'b1;
      fhm_pkg::STRAT_FOLLOW:    counted = follower;
      fhm_pkg::STRAT_NONFOLLOW: counted = !follower;
      default:                  counted = 1'b0;
    endcase
  end

  assign in_range = (32'(item_i.agent_value) < NUM_VALUES);
  assign raddr_o  = AW'(item_i.agent_value);

  // stage 1: bin data arrives, add one, write back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept_i && counted && in_range;
      if (flush_i) begin
        fwd_vld_q <= 1'b0;
      end else if (s1_vld_q) begin
        fwd_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q <= raddr_o;
    if (s1_vld_q) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= wdata_o;
    end
  end

  // the previous write may land in the same cycle as this read: forward it
  assign base    = (fwd_vld_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : rdata_i;
  assign wdata_o = (base == fhm_pkg::COUNT_MAX) ? base : base + 1'b1;
  assign we_o    = s1_vld_q;
  assign waddr_o = s1_addr_q;

endmodule

### sv/fhm_scan.sv
// Bin scan sequencer: clearing pass after reset, end-of-run argmax with clear.
// Depends on fhm_pkg; drives the bin RAM ports in the top level.
module fhm_scan #(
  parameter int unsigned NUM_VALUES = fhm_pkg::NUM_VALUES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           launch_i,
  input  fhm_pkg::run_t                  run_i,
  output logic [$clog2(NUM_VALUES)-1:0]  raddr_o,
  input  logic [fhm_pkg::COUNT_W-1:0]    rdata_i,
  output logic                           we_o,
  output logic [$clog2(NUM_VALUES)-1:0]  waddr_o,
  output logic                           busy_o,
  output logic                           done_o,
  output fhm_pkg::result_t               result_o
);

  localparam int unsigned AW = $clog2(NUM_VALUES);
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_VALUES - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DRAIN,
    S_SCAN,
    S_TAIL,
    S_EMIT
  } state_e;

  state_e                      state_q;
  logic [AW-1:0]               idx_q;
  logic                        rd_vld_q;
  logic [AW-1:0]               rd_idx_q;
  fhm_pkg::run_t               run_q;
  logic [fhm_pkg::COUNT_W-1:0] max_q;
  logic [AW-1:0]               max_idx_q;
  logic [fhm_pkg::COUNT_W-1:0] cm_q;
  logic                        done_q;
  fhm_pkg::result_t            result_q;
  logic                        media_hit;
  logic [fhm_pkg::FIELD_W-1:0] best;

  // bin of the current media value; out-of-range media keeps count zero
  assign media_hit = (32'(run_q.media) < NUM_VALUES) && (rd_idx_q == AW'(run_q.media));

  // first bin holding the global max wins only if it beats the media bin
  assign best = (!run_q.skip && (max_q > cm_q)) ? fhm_pkg::FIELD_W'(max_idx_q)
                                                 : run_q.media;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q   <= 1'b0;
      rd_vld_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == LAST_IDX) begin
            idx_q   <= '0;
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (launch_i) begin
            run_q     <= run_i;
            max_q     <= '0;
            max_idx_q <= '0;
            cm_q      <= '0;
            state_q   <= S_DRAIN;
          end
        end
        // last increment is written back this cycle
        S_DRAIN: begin
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          rd_vld_q <= 1'b1;
          rd_idx_q <= idx_q;
          idx_q    <= idx_q + 1'b1;
          if (idx_q == LAST_IDX) begin
            idx_q   <= '0;
            state_q <= S_TAIL;
          end
        end
        S_TAIL: begin
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          done_q             <= 1'b1;
          result_q.new_value <= best;
          result_q.changed   <= (best != run_q.media);
          state_q            <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      // data phase of the scan
      if (rd_vld_q) begin
        if (rdata_i > max_q) begin
          max_q     <= rdata_i;
          max_idx_q <= rd_idx_q;
        end
        if (media_hit) begin
          cm_q <= rdata_i;
        end
      end
    end
  end

  // RAM side: read ahead, write zero behind
  assign raddr_o  = idx_q;
  assign we_o     = (state_q == S_CLEAR) || rd_vld_q;
  assign waddr_o  = (state_q == S_CLEAR) ? idx_q : rd_idx_q;
  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

### sv/filtered_histogram_mode_top.sv
// Filtered histogram mode: top level with configuration registers and RAM muxing.
// Depends on fhm_pkg, fhm_ram, fhm_update, fhm_scan and the macros header.
//
// Usage:
//   Each request on item_i is one agent, taken at a clock edge with start high
//   and busy low. Agents that pass the strategy filter add one to the bin of
//   their agent value (saturating). Ordinary requests give no result and may
//   follow each other in every cycle: one read-modify-write of the bin RAM per
//   request, with the write of the previous request forwarded.
//   A request with is_last set ends the run. busy then stays high while the
//   bins are read once each through the RAM read port, compared and written
//   back to zero. done_o then pulses one cycle with result_o valid; busy is
//   low in that same cycle. The receiver cannot stall; a result is gone after
//   its strobe.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once
//   and belong between runs. After reset all registers are zero and busy is
//   high while the bin RAM is cleared.
`include "filtered_histogram_mode_top_macros.svh"

module filtered_histogram_mode_top #(
  parameter int unsigned NUM_VALUES = fhm_pkg::NUM_VALUES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  fhm_pkg::item_t                   item_i,
  output logic                             done_o,
  output fhm_pkg::result_t                 result_o,
  input  logic                             cfg_we_i,
  input  logic [fhm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [fhm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned AW = $clog2(NUM_VALUES);

  fhm_pkg::strategy_e          strategy_q;
  logic [fhm_pkg::FIELD_W-1:0] edit_q;
  logic [fhm_pkg::FIELD_W-1:0] follow_q;
  logic                        accept;
  logic                        launch;
  fhm_pkg::run_t               run;

  logic [AW-1:0]               upd_raddr;
  logic                        upd_we;
  logic [AW-1:0]               upd_waddr;
  logic [fhm_pkg::COUNT_W-1:0] upd_wdata;
  logic [AW-1:0]               scan_raddr;
  logic                        scan_we;
  logic [AW-1:0]               scan_waddr;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [fhm_pkg::COUNT_W-1:0] ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [fhm_pkg::COUNT_W-1:0] ram_rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strategy_q <= fhm_pkg::STRAT_FIXED;
      edit_q     <= '0;
      follow_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fhm_pkg::CFG_STRATEGY:     strategy_q <= fhm_pkg::strategy_e'(cfg_data_i[1:0]);
        fhm_pkg::CFG_EDIT_SECTION: edit_q     <= cfg_data_i;
        fhm_pkg::CFG_FOLLOWER:     follow_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept = start && !busy;
  assign launch = accept && item_i.is_last;

  // the edited section and unknown features keep the media value
  assign run.media = item_i.media_value;
  assign run.skip  = (item_i.feature_index == edit_q) ||
                     !(32'(item_i.feature_index) < fhm_pkg::NUM_FEATURES);

  fhm_update #(
    .NUM_VALUES (NUM_VALUES)
  ) u_update (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (item_i),
    .strategy_i (strategy_q),
    .follower_i (follow_q),
    .flush_i    (busy),
    .raddr_o    (upd_raddr),
    .rdata_i    (ram_rdata),
    .we_o       (upd_we),
    .waddr_o    (upd_waddr),
    .wdata_o    (upd_wdata)
  );

  fhm_scan #(
    .NUM_VALUES (NUM_VALUES)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .launch_i (launch),
    .run_i    (run),
    .raddr_o  (scan_raddr),
    .rdata_i  (ram_rdata),
    .we_o     (scan_we),
    .waddr_o  (scan_waddr),
    .busy_o   (busy),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // RAM port sharing: the last increment may still write while the scan waits
  assign ram_we    = upd_we || scan_we;
  assign ram_waddr = upd_we ? upd_waddr : scan_waddr;
  assign ram_wdata = upd_we ? upd_wdata : '0;
  assign ram_raddr = busy ? scan_raddr : upd_raddr;

  fhm_ram #(
    .WIDTH (fhm_pkg::COUNT_W),
    .DEPTH (NUM_VALUES)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // checks
  `FHM_ASSERT(a_done_single, clk_i, rst_ni, done_o |=> !done_o)
  `FHM_ASSERT(a_done_after_busy, clk_i, rst_ni, done_o |-> (!busy && $past(busy)))
  `FHM_ASSERT(a_last_busy, clk_i, rst_ni, (start && !busy && item_i.is_last) |=> busy)
  `FHM_ASSERT_NEVER(a_no_write_clash, clk_i, rst_ni, upd_we && scan_we)

endmodule

### bench/testbench.sv
// Self-checking bench for filtered_histogram_mode_top: agent requests grouped into runs.
// Depends on fhm_pkg and the block's RTL. Results are checked against an in-bench predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fhm_pkg::*;

  localparam int unsigned NV          = NUM_VALUES_DEF;
  localparam int unsigned SETTLE      = NV + 8;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_ITEMS = 100;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  start      = 1'b0;
  logic                  busy;
  item_t                 item_i     = '0;
  logic                  done_o;
  result_t               result_o;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // requests waiting to be driven, results waiting to arrive
  item_t   agent_q[$];
  result_t mode_q[$];
  result_t due_r;

  int unsigned queued_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned err_cnt      = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned gap_left     = 0;
  logic        taken        = 1'b0;
  bit          no_gaps      = 1'b0;

  // predictor state: register copies and histogram
  strategy_e          mdl_strategy;
  logic [FIELD_W-1:0] mdl_edit;
  logic [FIELD_W-1:0] mdl_follower;
  logic [COUNT_W-1:0] bin_tally [NV];

  // register values the stimulus generator aims at
  logic [FIELD_W-1:0] gen_edit     = '0;
  logic [FIELD_W-1:0] gen_follower = '0;

  filtered_histogram_mode_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // count one agent; on the last one of a run, scan the bins and queue the mode
  function automatic void tally_agent(input item_t a);
    logic               counted;
    logic [FIELD_W-1:0] best;
    logic [COUNT_W-1:0] best_cnt;
    result_t            r;
    case (mdl_strategy)
      STRAT_ALL:       counted = 1'b1;
      STRAT_FOLLOW:    counted = (a.agent_section_value == mdl_follower);
      STRAT_NONFOLLOW: counted = (a.agent_section_value != mdl_follower);
      default:         counted = 1'b0;
    endcase
    if (counted && a.agent_value < NV && bin_tally[a.agent_value] != COUNT_MAX)
      bin_tally[a.agent_value] = bin_tally[a.agent_value] + 1'b1;
    if (a.is_last) begin
      best = a.media_value;
      if (a.feature_index != mdl_edit && a.feature_index < NUM_FEATURES) begin
        // candidate starts at the media value; only a strictly larger count wins
        for (int i = 0; i < NV; i++) begin
          best_cnt = (best < NV) ? bin_tally[best] : '0;
          if (bin_tally[i] > best_cnt) best = FIELD_W'(i);
        end
      end
      r.new_value = best;
      r.changed   = (best != a.media_value);
      mode_q.push_back(r);
      foreach (bin_tally[i]) bin_tally[i] = '0;
    end
  endfunction

  // monitor: result check, register tracking, request prediction, timeout
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken        <= 1'b0;
      mdl_strategy = STRAT_FIXED;
      mdl_edit     = '0;
      mdl_follower = '0;
      foreach (bin_tally[i]) bin_tally[i] = '0;
    end else if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("Test completed with failures");
      $finish;
    end else begin
      cycle_cnt++;
      if (done_o === 1'b1) begin
        if (mode_q.size() == 0) begin
          err_cnt++;
          $display("%0t: result with none expected: new_value %0d changed %0b",
                   $time, result_o.new_value, result_o.changed);
        end else begin
          due_r = mode_q.pop_front();
          if (result_o.new_value !== due_r.new_value) begin
            err_cnt++;
            $display("%0t: new_value expected %0d got %0d",
                     $time, due_r.new_value, result_o.new_value);
          end
          if (result_o.changed !== due_r.changed) begin
            err_cnt++;
            $display("%0t: changed expected %0b got %0b",
                     $time, due_r.changed, result_o.changed);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_STRATEGY:     mdl_strategy = strategy_e'(cfg_data_i[1:0]);
          CFG_EDIT_SECTION: mdl_edit     = cfg_data_i;
          CFG_FOLLOWER:     mdl_follower = cfg_data_i;
          default: ;
        endcase
      end
      taken <= start && !busy;
      if (start && !busy) begin
        accepted_cnt++;
        tally_agent(item_i);
      end
    end
  end

  // driver: one request per handshake, random gap drawn per request
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else if (start && !taken) begin
      // request still pending, hold it
    end else if (gap_left != 0) begin
      start    <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (agent_q.size() != 0) begin
      item_i   <= agent_q.pop_front();
      start    <= 1'b1;
      gap_left <= (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    end else begin
      start    <= 1'b0;
    end
  end

  task automatic push_agent(input logic [FIELD_W-1:0] feat, input logic [FIELD_W-1:0] aval,
                            input logic [FIELD_W-1:0] sval, input logic [FIELD_W-1:0] media,
                            input logic last);
    item_t a;
    a.feature_index       = feat;
    a.agent_value         = aval;
    a.agent_section_value = sval;
    a.media_value         = media;
    a.is_last             = last;
    agent_q.push_back(a);
    queued_cnt++;
  endtask

  // all three registers, written back to back while the block is idle
  task automatic set_regs(input strategy_e s, input logic [FIELD_W-1:0] e,
                          input logic [FIELD_W-1:0] f);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_STRATEGY;
    cfg_data_i <= CFG_DATA_W'(s);
    @(negedge clk_i);
    cfg_idx_i  <= CFG_EDIT_SECTION;
    cfg_data_i <= e;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_FOLLOWER;
    cfg_data_i <= f;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    gen_edit     = e;
    gen_follower = f;
    @(posedge clk_i);
  endtask

  // all requests taken, all results in, then let the scan pipeline drain
  task automatic wait_idle();
    do @(negedge clk_i);
    while (accepted_cnt != queued_cnt || mode_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // one run: a hot value, a runner-up and some noise, closed by is_last
  task automatic queue_run();
    int unsigned        len;
    logic [FIELD_W-1:0] feat;
    logic [FIELD_W-1:0] hot;
    logic [FIELD_W-1:0] alt;
    logic [FIELD_W-1:0] media;
    logic [FIELD_W-1:0] aval;
    logic [FIELD_W-1:0] sval;
    logic               last;
    len   = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    feat  = ($urandom_range(0, 5) == 0) ? gen_edit : FIELD_W'($urandom);
    hot   = FIELD_W'($urandom);
    alt   = FIELD_W'($urandom);
    media = ($urandom_range(0, 2) == 0) ? hot : FIELD_W'($urandom);
    for (int k = 0; k < len; k++) begin
      last = (k == len - 1);
      case ($urandom_range(0, 3))
        0:       aval = FIELD_W'($urandom);
        1:       aval = alt;
        default: aval = hot;
      endcase
      sval = $urandom_range(0, 1) ? gen_follower : FIELD_W'($urandom);
      // stray feature index and media value on inner agents are ignored by the block
      if (last)
        push_agent(feat, aval, sval, media, 1'b1);
      else
        push_agent(($urandom_range(0, 15) == 0) ? FIELD_W'($urandom) : feat, aval, sval,
                   FIELD_W'($urandom), 1'b0);
    end
  endtask

  initial begin
    int unsigned phase_start;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fixed strategy after reset: nothing counted, media value kept
    push_agent(4'd3, 4'd15, 4'd15, 4'd0, 1'b0);
    push_agent(4'd3, 4'd15, 4'd0, 4'd0, 1'b1);
    wait_idle();

    set_regs(STRAT_ALL, 4'd15, 4'd15);
    // plain majority
    push_agent(4'd0, 4'd15, 4'd0, 4'd0, 1'b0);
    push_agent(4'd0, 4'd15, 4'd15, 4'd0, 1'b0);
    push_agent(4'd0, 4'd0, 4'd0, 4'd0, 1'b1);
    // feature equal to the edited section
    push_agent(4'd15, 4'd9, 4'd9, 4'd2, 1'b0);
    push_agent(4'd15, 4'd9, 4'd0, 4'd2, 1'b1);
    // tie with the media value: media kept
    push_agent(4'd1, 4'd7, 4'd3, 4'd9, 1'b0);
    push_agent(4'd1, 4'd9, 4'd3, 4'd9, 1'b1);
    // tie between two bins, media uncounted: lower index wins
    push_agent(4'd2, 4'd4, 4'd0, 4'd15, 1'b0);
    push_agent(4'd2, 4'd6, 4'd0, 4'd15, 1'b1);
    wait_idle();

    // followers only, then the same agents with non-followers only
    set_regs(STRAT_FOLLOW, 4'd0, 4'd15);
    push_agent(4'd5, 4'd4, 4'd15, 4'd0, 1'b0);
    push_agent(4'd5, 4'd2, 4'd0, 4'd0, 1'b0);
    push_agent(4'd5, 4'd2, 4'd1, 4'd0, 1'b0);
    push_agent(4'd5, 4'd4, 4'd15, 4'd0, 1'b1);
    wait_idle();
    set_regs(STRAT_NONFOLLOW, 4'd0, 4'd15);
    push_agent(4'd5, 4'd4, 4'd15, 4'd0, 1'b0);
    push_agent(4'd5, 4'd2, 4'd0, 4'd0, 1'b0);
    push_agent(4'd5, 4'd2, 4'd1, 4'd0, 1'b0);
    push_agent(4'd5, 4'd4, 4'd15, 4'd0, 1'b1);
    push_agent(4'd0, 4'd8, 4'd3, 4'd1, 1'b1);
    wait_idle();

    // random runs under a series of register settings
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       set_regs(STRAT_NONFOLLOW, 4'd0, 4'd0);
        1:       set_regs(STRAT_ALL, 4'd15, 4'd15);
        2:       set_regs(STRAT_FIXED, FIELD_W'($urandom), FIELD_W'($urandom));
        3:       set_regs(STRAT_FOLLOW, FIELD_W'($urandom), FIELD_W'($urandom));
        default: set_regs(strategy_e'($urandom_range(0, 3)), FIELD_W'($urandom),
                          FIELD_W'($urandom));
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      phase_start = queued_cnt;
      while (queued_cnt - phase_start < PHASE_ITEMS) queue_run();
      wait_idle();
    end

    if (err_cnt == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/fhm_pkg.sv
sv/fhm_ram.sv
sv/fhm_update.sv
sv/fhm_scan.sv
sv/filtered_histogram_mode_top.sv
bench/testbench.sv
